@@ hdl/transfer_function_classifier_macros.svh @@
// ----------------------------------------------------------------------------
// transfer function classifier assertion macros
// concurrent assertion wrappers used by the checker file
// ----------------------------------------------------------------------------
`ifndef TRANSFER_FUNCTION_CLASSIFIER_MACROS_SVH
`define TRANSFER_FUNCTION_CLASSIFIER_MACROS_SVH

// same-cycle implication, disabled during reset
`define TFC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("transfer function classifier assertion failed");

// next-cycle implication, disabled during reset
`define TFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("transfer function classifier assertion failed");

`endif

@@ hdl/tfc_pkg.sv @@
// ----------------------------------------------------------------------------
// tfc_pkg
// constants and types of the transfer function classifier
// ----------------------------------------------------------------------------
package tfc_pkg;

    // sizing
    localparam int TABLE_DEPTH  = 256;
    localparam int SAMPLE_WIDTH = 32;
    localparam int FRAC_BITS    = 16;

    localparam int ADDR_W   = $clog2(TABLE_DEPTH);
    localparam int NORM_W   = FRAC_BITS + 1;
    localparam int DIFF_W   = 33;
    localparam int MAG_W    = 32;
    localparam int SCALE_W  = 33;
    localparam int PROD_W   = MAG_W + SCALE_W;
    localparam int T_W      = NORM_W + ADDR_W;
    localparam int I_W      = T_W - FRAC_BITS;
    localparam int CHAN_W   = 16;
    localparam int BL_W     = CHAN_W + FRAC_BITS + 1;
    localparam int ENTRY_W  = 4 * CHAN_W;
    localparam int INDEX_W  = 8;
    localparam int TE_W     = 9;
    localparam int VMIN_W   = 32;

    localparam int FRAC_ONE  = 1 << FRAC_BITS;
    localparam int FRAC_HALF = 1 << (FRAC_BITS - 1);

    // configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;

    localparam logic [SCALE_W-1:0] SCALE_ONE   = {1'b1, 32'd0};
    localparam logic [VMIN_W-1:0]  VMIN_RESET  = '0;
    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65537);
    localparam logic [TE_W-1:0]    TE_RESET    = TE_W'(256);

    // register indexes, byte address 8*i
    typedef enum logic [1:0] {
        REG_VALUE_MIN     = 2'd0,
        REG_RANGE_SCALE   = 2'd1,
        REG_TABLE_ENTRIES = 2'd2
    } cfg_reg_t;

    // input modes
    localparam logic MODE_CLASSIFY = 1'b0;
    localparam logic MODE_WRITE    = 1'b1;

    // one table entry as stored
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] opacity;
    } entry_t;

endpackage

@@ hdl/tfc_ram.sv @@
// ----------------------------------------------------------------------------
// tfc_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module tfc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered reads, held while re is low
    always_ff @(posedge clk) begin
        if (re) begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

@@ hdl/transfer_function_classifier.sv @@
// ----------------------------------------------------------------------------
// transfer_function_classifier
// maps signed samples through a linearly interpolated color/opacity table
// ----------------------------------------------------------------------------
// Five-stage pipeline that takes one transaction per cycle while the output
// is not stalled and presents each classified result on m_valid: stage one
// subtracts value_min, stage two multiplies by range_scale saturated at one,
// stage three clamps to [0,1] and scales by the last entry index in use
// (table_entries - 1, clamped to [0,255]), stage four reads the two
// neighboring entries from a dual-read table ram, stage five blends them.
// Mode 1 transactions write one table entry when they reach the table stage and
// produce no result; writes and reads keep transaction order. The pipeline
// advances whenever the output register is empty or taken, so s_ready only
// drops while a result waits on m_ready.
module transfer_function_classifier (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // input channel
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic                                      s_mode,
    input  logic signed [tfc_pkg::SAMPLE_WIDTH-1:0]   s_sample,
    input  logic [tfc_pkg::INDEX_W-1:0]               s_entry_index,
    input  logic [tfc_pkg::CHAN_W-1:0]                s_entry_red,
    input  logic [tfc_pkg::CHAN_W-1:0]                s_entry_green,
    input  logic [tfc_pkg::CHAN_W-1:0]                s_entry_blue,
    input  logic [tfc_pkg::CHAN_W-1:0]                s_entry_opacity,
    // result channel
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic [tfc_pkg::CHAN_W-1:0]                m_red,
    output logic [tfc_pkg::CHAN_W-1:0]                m_green,
    output logic [tfc_pkg::CHAN_W-1:0]                m_blue,
    output logic [tfc_pkg::CHAN_W-1:0]                m_opacity,
    // configuration port
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [tfc_pkg::PADDR_W-1:0]               paddr,
    input  logic [tfc_pkg::PDATA_W-1:0]               pwdata,
    output logic [tfc_pkg::PDATA_W-1:0]               prdata,
    output logic                                      pready
);

    // configuration registers
    logic signed [tfc_pkg::VMIN_W-1:0] value_min_reg;
    logic [tfc_pkg::SCALE_W-1:0]       range_scale_reg;
    logic [tfc_pkg::TE_W-1:0]          table_entries_reg;
    logic                              cfg_write;
    tfc_pkg::cfg_reg_t                 cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = tfc_pkg::cfg_reg_t'(paddr[4:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_min_reg     <= tfc_pkg::VMIN_RESET;
            range_scale_reg   <= tfc_pkg::SCALE_RESET;
            table_entries_reg <= tfc_pkg::TE_RESET;
        end else if (cfg_write) begin
            unique case (cfg_sel)
                tfc_pkg::REG_VALUE_MIN:     value_min_reg <= pwdata[tfc_pkg::VMIN_W-1:0];
                tfc_pkg::REG_RANGE_SCALE:   range_scale_reg <= pwdata[tfc_pkg::SCALE_W-1:0];
                tfc_pkg::REG_TABLE_ENTRIES: table_entries_reg <= pwdata[tfc_pkg::TE_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (cfg_sel)
            tfc_pkg::REG_VALUE_MIN:     prdata = tfc_pkg::PDATA_W'($unsigned(value_min_reg));
            tfc_pkg::REG_RANGE_SCALE:   prdata = tfc_pkg::PDATA_W'(range_scale_reg);
            tfc_pkg::REG_TABLE_ENTRIES: prdata = tfc_pkg::PDATA_W'(table_entries_reg);
            default:                    prdata = '0;
        endcase
    end

    // derived configuration: saturated scale and last entry in use
    logic [tfc_pkg::SCALE_W-1:0] scale_sat;
    logic [tfc_pkg::ADDR_W-1:0]  last_idx;

    always_comb begin
        scale_sat = (range_scale_reg > tfc_pkg::SCALE_ONE) ? tfc_pkg::SCALE_ONE
                                                           : range_scale_reg;
        if (table_entries_reg == '0) begin
            last_idx = '0;
        end else if (32'(table_entries_reg) > 32'(tfc_pkg::TABLE_DEPTH)) begin
            last_idx = tfc_pkg::ADDR_W'(tfc_pkg::TABLE_DEPTH - 1);
        end else begin
            last_idx = tfc_pkg::ADDR_W'(table_entries_reg - tfc_pkg::TE_W'(1));
        end
    end

    // pipeline advance: output register empty or being taken
    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    assign adv     = !v5_reg || m_ready;
    assign s_ready = adv;

    // stage 1: offset from value_min
    logic                              mode1_reg;
    logic                              pos1_reg;
    logic [tfc_pkg::MAG_W-1:0]         mag1_reg;
    tfc_pkg::entry_t                   ent1_reg;
    logic [tfc_pkg::INDEX_W-1:0]       idx1_reg;
    logic signed [tfc_pkg::DIFF_W-1:0] diff;

    assign diff = tfc_pkg::DIFF_W'(s_sample) - tfc_pkg::DIFF_W'(value_min_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            mode1_reg <= s_mode;
            pos1_reg  <= !diff[tfc_pkg::DIFF_W-1] && (diff != '0);
            mag1_reg  <= diff[tfc_pkg::MAG_W-1:0];
            ent1_reg  <= '{red: s_entry_red, green: s_entry_green,
                           blue: s_entry_blue, opacity: s_entry_opacity};
            idx1_reg  <= s_entry_index;
        end
    end

    // stage 2: scale product
    logic                        mode2_reg;
    logic                        pos2_reg;
    logic [tfc_pkg::PROD_W-1:0]  prod2_reg;
    tfc_pkg::entry_t             ent2_reg;
    logic [tfc_pkg::INDEX_W-1:0] idx2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            mode2_reg <= mode1_reg;
            pos2_reg  <= pos1_reg;
            prod2_reg <= tfc_pkg::PROD_W'(mag1_reg) * tfc_pkg::PROD_W'(scale_sat);
            ent2_reg  <= ent1_reg;
            idx2_reg  <= idx1_reg;
        end
    end

    // stage 3: clamp to [0,1] and scale by the last entry index in use
    logic [tfc_pkg::NORM_W-1:0]  norm;
    logic                        mode3_reg;
    logic [tfc_pkg::T_W-1:0]     t3_reg;
    tfc_pkg::entry_t             ent3_reg;
    logic [tfc_pkg::INDEX_W-1:0] idx3_reg;

    always_comb begin
        if (!pos2_reg) begin
            norm = '0;
        end else if (prod2_reg[tfc_pkg::PROD_W-1:32] != '0) begin
            norm = tfc_pkg::NORM_W'(tfc_pkg::FRAC_ONE);
        end else begin
            norm = tfc_pkg::NORM_W'(prod2_reg[31 -: tfc_pkg::FRAC_BITS]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mode3_reg <= mode2_reg;
            t3_reg    <= tfc_pkg::T_W'(norm) * tfc_pkg::T_W'(last_idx);
            ent3_reg  <= ent2_reg;
            idx3_reg  <= idx2_reg;
        end
    end

    // table stage: neighbor indexes, reads and entry writes in order
    logic [tfc_pkg::I_W-1:0]       i0_full;
    logic [tfc_pkg::ADDR_W-1:0]    i0;
    logic [tfc_pkg::ADDR_W-1:0]    i1;
    logic [tfc_pkg::FRAC_BITS-1:0] frac3;
    logic                          tbl_we;
    logic [tfc_pkg::ENTRY_W-1:0]   rd0;
    logic [tfc_pkg::ENTRY_W-1:0]   rd1;

    always_comb begin
        i0_full = t3_reg[tfc_pkg::T_W-1:tfc_pkg::FRAC_BITS];
        frac3   = t3_reg[tfc_pkg::FRAC_BITS-1:0];
        if (i0_full > tfc_pkg::I_W'(last_idx)) begin
            i0 = last_idx;
        end else begin
            i0 = i0_full[tfc_pkg::ADDR_W-1:0];
        end
        i1 = (i0 == last_idx) ? i0 : i0 + tfc_pkg::ADDR_W'(1);
    end

    assign tbl_we = adv && v3_reg && (mode3_reg == tfc_pkg::MODE_WRITE) &&
                    (32'(idx3_reg) < 32'(tfc_pkg::TABLE_DEPTH));

    tfc_ram #(
        .WIDTH (tfc_pkg::ENTRY_W),
        .DEPTH (tfc_pkg::TABLE_DEPTH)
    ) u_table (
        .clk     (aclk),
        .we      (tbl_we),
        .waddr   (tfc_pkg::ADDR_W'(idx3_reg)),
        .wdata   (ent3_reg),
        .re      (adv),
        .raddr_a (i0),
        .raddr_b (i1),
        .rdata_a (rd0),
        .rdata_b (rd1)
    );

    logic [tfc_pkg::FRAC_BITS-1:0] frac4_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            frac4_reg <= frac3;
        end
    end

    // stage 5: linear blend with round half up
    function automatic logic [tfc_pkg::CHAN_W-1:0] blend(
        input logic [tfc_pkg::CHAN_W-1:0]    a,
        input logic [tfc_pkg::CHAN_W-1:0]    b,
        input logic [tfc_pkg::FRAC_BITS-1:0] f
    );
        logic [tfc_pkg::BL_W-1:0] sum;
        sum = tfc_pkg::BL_W'(f) * tfc_pkg::BL_W'(b)
            + (tfc_pkg::BL_W'(tfc_pkg::FRAC_ONE) - tfc_pkg::BL_W'(f)) * tfc_pkg::BL_W'(a)
            + tfc_pkg::BL_W'(tfc_pkg::FRAC_HALF);
        return sum[tfc_pkg::FRAC_BITS +: tfc_pkg::CHAN_W];
    endfunction

    tfc_pkg::entry_t e0, e1;
    logic [tfc_pkg::CHAN_W-1:0] red_reg, green_reg, blue_reg, opacity_reg;

    assign e0 = rd0;
    assign e1 = rd1;

    always_ff @(posedge aclk) begin
        if (adv) begin
            red_reg     <= blend(e0.red, e1.red, frac4_reg);
            green_reg   <= blend(e0.green, e1.green, frac4_reg);
            blue_reg    <= blend(e0.blue, e1.blue, frac4_reg);
            opacity_reg <= blend(e0.opacity, e1.opacity, frac4_reg);
        end
    end

    // valid bits; table writes drop out after the table stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg && (mode3_reg == tfc_pkg::MODE_CLASSIFY);
            v5_reg <= v4_reg;
        end
    end

    assign m_valid   = v5_reg;
    assign m_red     = red_reg;
    assign m_green   = green_reg;
    assign m_blue    = blue_reg;
    assign m_opacity = opacity_reg;

endmodule

@@ hdl/tfc_checker.sv @@
// ----------------------------------------------------------------------------
// tfc_checker
// port-level assertions for the transfer function classifier
// ----------------------------------------------------------------------------
`include "transfer_function_classifier_macros.svh"

module tfc_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [tfc_pkg::CHAN_W-1:0]  m_red,
    input logic [tfc_pkg::CHAN_W-1:0]  m_green,
    input logic [tfc_pkg::CHAN_W-1:0]  m_blue,
    input logic [tfc_pkg::CHAN_W-1:0]  m_opacity,
    input logic                        pready
);

    // input side stalls only while a result waits
    `TFC_ASSERT_IMPL(a_ready_tracks_output, aclk, aresetn, 1'b1, s_ready == (!m_valid || m_ready))

    // configuration port never inserts wait states
    `TFC_ASSERT_IMPL(a_pready_high, aclk, aresetn, 1'b1, pready)

    // pipeline is empty right after reset
    `TFC_ASSERT_IMPL(a_empty_after_reset, aclk, aresetn, $past(!aresetn), !m_valid)

    // a stalled result transaction holds its payload
    `TFC_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_red) && $stable(m_green) && $stable(m_blue) && $stable(m_opacity))

endmodule

bind transfer_function_classifier tfc_checker u_tfc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_red     (m_red),
    .m_green   (m_green),
    .m_blue    (m_blue),
    .m_opacity (m_opacity),
    .pready    (pready)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench of the transfer function classifier
// ----------------------------------------------------------------------------
// Fills the whole color/opacity table first, then streams classify and write
// transactions through the block under several register settings, extremes
// included. A scoreboard keeps its own table and register copies, predicts
// the interpolated color and opacity of every accepted classification and
// checks each returned result in order. Both channels idle at random, and
// registers are written and read back only while the pipeline is empty.
module tb_top;

    localparam int PIPE_DRAIN      = 8;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int IDLE_PCT        = 23;

    // one input transaction
    typedef struct {
        logic                                    mode;
        logic signed [tfc_pkg::SAMPLE_WIDTH-1:0] sample;
        logic [tfc_pkg::INDEX_W-1:0]             index;
        tfc_pkg::entry_t                         entry;
    } tf_txn_t;

    // color/opacity predictor with its own table and register copies
    class tf_scoreboard;
        logic signed [tfc_pkg::VMIN_W-1:0] value_min;
        logic [tfc_pkg::SCALE_W-1:0]       range_scale;
        logic [tfc_pkg::TE_W-1:0]          table_entries;
        tfc_pkg::entry_t                   tf_table[tfc_pkg::TABLE_DEPTH];
        tfc_pkg::entry_t                   expected_colors[$];
        int                                mismatches;
        int                                n_classified;
        int                                n_written;

        function new();
            value_min     = tfc_pkg::VMIN_RESET;
            range_scale   = tfc_pkg::SCALE_RESET;
            table_entries = tfc_pkg::TE_RESET;
        endfunction

        function void set_register(tfc_pkg::cfg_reg_t r, bit [63:0] v);
            case (r)
                tfc_pkg::REG_VALUE_MIN:     value_min     = v[tfc_pkg::VMIN_W-1:0];
                tfc_pkg::REG_RANGE_SCALE:   range_scale   = v[tfc_pkg::SCALE_W-1:0];
                tfc_pkg::REG_TABLE_ENTRIES: table_entries = v[tfc_pkg::TE_W-1:0];
                default: ;
            endcase
        endfunction

        function bit [63:0] register_value(tfc_pkg::cfg_reg_t r);
            case (r)
                tfc_pkg::REG_VALUE_MIN:     return 64'(unsigned'(value_min));
                tfc_pkg::REG_RANGE_SCALE:   return 64'(range_scale);
                tfc_pkg::REG_TABLE_ENTRIES: return 64'(table_entries);
                default:                    return '0;
            endcase
        endfunction

        // linear blend of two channel values, rounded half up
        function logic [tfc_pkg::CHAN_W-1:0] mix(logic [tfc_pkg::CHAN_W-1:0] a,
                                                 logic [tfc_pkg::CHAN_W-1:0] b,
                                                 bit [63:0] frac);
            bit [63:0] sum;
            sum = frac * 64'(b) + (64'(tfc_pkg::FRAC_ONE) - frac) * 64'(a)
                + 64'(tfc_pkg::FRAC_HALF);
            return sum[tfc_pkg::FRAC_BITS +: tfc_pkg::CHAN_W];
        endfunction

        function tfc_pkg::entry_t interpolate_entry(
            logic signed [tfc_pkg::SAMPLE_WIDTH-1:0] sample);
            longint          diff;
            bit [63:0]       scale_eff, prod, norm, span, t, i0, i1, frac;
            tfc_pkg::entry_t lo, hi, res;
            diff      = longint'(sample) - longint'(value_min);
            scale_eff = (range_scale > tfc_pkg::SCALE_ONE) ? 64'(tfc_pkg::SCALE_ONE)
                                                           : 64'(range_scale);
            // normalize and clamp to [0,1]
            if (diff <= 0) begin
                norm = 0;
            end else begin
                prod = 64'(diff) * scale_eff;
                norm = (prod >= (64'd1 << 32)) ? 64'(tfc_pkg::FRAC_ONE)
                                               : (prod >> (32 - tfc_pkg::FRAC_BITS));
            end
            // effective number of entries
            if (table_entries == 0)
                span = 1;
            else if (table_entries > tfc_pkg::TABLE_DEPTH)
                span = tfc_pkg::TABLE_DEPTH;
            else
                span = 64'(table_entries);
            t    = norm * (span - 1);
            i0   = t >> tfc_pkg::FRAC_BITS;
            frac = t & 64'(tfc_pkg::FRAC_ONE - 1);
            if (i0 > span - 1)
                i0 = span - 1;
            i1 = (i0 != span - 1) ? i0 + 1 : i0;
            lo = tf_table[i0];
            hi = tf_table[i1];
            res.red     = mix(lo.red, hi.red, frac);
            res.green   = mix(lo.green, hi.green, frac);
            res.blue    = mix(lo.blue, hi.blue, frac);
            res.opacity = mix(lo.opacity, hi.opacity, frac);
            return res;
        endfunction

        function void note_transaction(tf_txn_t txn);
            if (txn.mode == tfc_pkg::MODE_WRITE) begin
                tf_table[txn.index] = txn.entry;
                n_written++;
            end else begin
                expected_colors = {expected_colors, interpolate_entry(txn.sample)};
                n_classified++;
            end
        endfunction

        function void compare_field(string name, logic [tfc_pkg::CHAN_W-1:0] exp_v,
                                    logic [tfc_pkg::CHAN_W-1:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_result(tfc_pkg::entry_t got);
            tfc_pkg::entry_t exp_e;
            if (expected_colors.size() == 0) begin
                $error("result transaction with no classification pending");
                mismatches++;
                return;
            end
            exp_e = expected_colors.pop_front();
            compare_field("red", exp_e.red, got.red);
            compare_field("green", exp_e.green, got.green);
            compare_field("blue", exp_e.blue, got.blue);
            compare_field("opacity", exp_e.opacity, got.opacity);
        endfunction

        function int pending();
            return expected_colors.size();
        endfunction
    endclass

    logic                                    aclk            = 1'b0;
    logic                                    aresetn         = 1'b0;
    logic                                    s_valid         = 1'b0;
    logic                                    s_ready;
    logic                                    s_mode          = tfc_pkg::MODE_CLASSIFY;
    logic signed [tfc_pkg::SAMPLE_WIDTH-1:0] s_sample        = '0;
    logic [tfc_pkg::INDEX_W-1:0]             s_entry_index   = '0;
    logic [tfc_pkg::CHAN_W-1:0]              s_entry_red     = '0;
    logic [tfc_pkg::CHAN_W-1:0]              s_entry_green   = '0;
    logic [tfc_pkg::CHAN_W-1:0]              s_entry_blue    = '0;
    logic [tfc_pkg::CHAN_W-1:0]              s_entry_opacity = '0;
    logic                                    m_valid;
    logic                                    m_ready         = 1'b0;
    logic [tfc_pkg::CHAN_W-1:0]              m_red;
    logic [tfc_pkg::CHAN_W-1:0]              m_green;
    logic [tfc_pkg::CHAN_W-1:0]              m_blue;
    logic [tfc_pkg::CHAN_W-1:0]              m_opacity;
    logic                                    psel            = 1'b0;
    logic                                    penable         = 1'b0;
    logic                                    pwrite          = 1'b0;
    logic [tfc_pkg::PADDR_W-1:0]             paddr           = '0;
    logic [tfc_pkg::PDATA_W-1:0]             pwdata          = '0;
    logic [tfc_pkg::PDATA_W-1:0]             prdata;
    logic                                    pready;

    tf_scoreboard sb = new();
    tf_txn_t      stim_q[$];
    bit           steady      = 1'b0;
    int           reg_errors  = 0;
    int           idle_cycles = 0;
    int           settings    = 0;

    transfer_function_classifier u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_sample        (s_sample),
        .s_entry_index   (s_entry_index),
        .s_entry_red     (s_entry_red),
        .s_entry_green   (s_entry_green),
        .s_entry_blue    (s_entry_blue),
        .s_entry_opacity (s_entry_opacity),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_red           (m_red),
        .m_green         (m_green),
        .m_blue          (m_blue),
        .m_opacity       (m_opacity),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // result side back-pressure
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // transaction monitor
    always @(posedge aclk) begin
        tf_txn_t txn;
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result('{red: m_red, green: m_green, blue: m_blue,
                                  opacity: m_opacity});
            if (s_valid && s_ready) begin
                txn.mode   = s_mode;
                txn.sample = s_sample;
                txn.index  = s_entry_index;
                txn.entry  = '{red: s_entry_red, green: s_entry_green,
                               blue: s_entry_blue, opacity: s_entry_opacity};
                sb.note_transaction(txn);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // append one transaction to the stimulus queue
    function automatic void queue_txn(tf_txn_t txn);
        stim_q = {stim_q, txn};
    endfunction

    function automatic tf_txn_t classify_txn(logic signed [tfc_pkg::SAMPLE_WIDTH-1:0] sample);
        tf_txn_t txn;
        txn.mode   = tfc_pkg::MODE_CLASSIFY;
        txn.sample = sample;
        txn.index  = tfc_pkg::INDEX_W'($urandom);
        txn.entry  = tfc_pkg::entry_t'({$urandom, $urandom});
        return txn;
    endfunction

    function automatic tf_txn_t write_txn(logic [tfc_pkg::INDEX_W-1:0] index,
                                          tfc_pkg::entry_t entry);
        tf_txn_t txn;
        txn.mode   = tfc_pkg::MODE_WRITE;
        txn.sample = tfc_pkg::SAMPLE_WIDTH'($urandom);
        txn.index  = index;
        txn.entry  = entry;
        return txn;
    endfunction

    // sample mostly inside the mapped range, some at its lower edge, some anywhere
    function automatic logic signed [tfc_pkg::SAMPLE_WIDTH-1:0] pick_sample();
        bit [63:0] scale_eff, width, offset;
        int        roll;
        scale_eff = (sb.range_scale > tfc_pkg::SCALE_ONE) ? 64'(tfc_pkg::SCALE_ONE)
                                                          : 64'(sb.range_scale);
        width     = (scale_eff == 0) ? (64'd1 << 32)
                                     : ((64'd1 << 32) + scale_eff - 1) / scale_eff;
        roll      = $urandom_range(99);
        if (roll < 65) begin
            offset = {$urandom, $urandom} % (width + 1);
            return sb.value_min + tfc_pkg::SAMPLE_WIDTH'(offset);
        end else if (roll < 80) begin
            return sb.value_min + tfc_pkg::SAMPLE_WIDTH'($urandom_range(4)) - 2;
        end
        return tfc_pkg::SAMPLE_WIDTH'($urandom);
    endfunction

    // drain the stimulus queue over the input channel
    task automatic send_all();
        tf_txn_t txn;
        while (stim_q.size() != 0) begin
            txn = stim_q.pop_front();
            if (!steady && $urandom_range(99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while ($urandom_range(99) < IDLE_PCT);
            end
            s_valid         <= 1'b1;
            s_mode          <= txn.mode;
            s_sample        <= txn.sample;
            s_entry_index   <= txn.index;
            s_entry_red     <= txn.entry.red;
            s_entry_green   <= txn.entry.green;
            s_entry_blue    <= txn.entry.blue;
            s_entry_opacity <= txn.entry.opacity;
            do @(posedge aclk); while (!s_ready);
        end
        s_valid <= 1'b0;
    endtask

    // wait for all results, then let trailing table writes leave the pipeline
    task automatic settle();
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (PIPE_DRAIN) @(posedge aclk);
    endtask

    task automatic apb_access(bit wr, tfc_pkg::cfg_reg_t r, bit [63:0] wdata,
                              output bit [63:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {r, 3'b000};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_register(tfc_pkg::cfg_reg_t r);
        bit [63:0] rd, mask;
        case (r)
            tfc_pkg::REG_VALUE_MIN:   mask = (64'd1 << tfc_pkg::VMIN_W) - 1;
            tfc_pkg::REG_RANGE_SCALE: mask = (64'd1 << tfc_pkg::SCALE_W) - 1;
            default:                  mask = (64'd1 << tfc_pkg::TE_W) - 1;
        endcase
        apb_access(1'b0, r, '0, rd);
        if ((rd & mask) != sb.register_value(r)) begin
            $error("%s: expected %0h, actual %0h", r.name(), sb.register_value(r),
                   rd & mask);
            reg_errors++;
        end
    endtask

    task automatic write_reg(tfc_pkg::cfg_reg_t r, bit [63:0] v);
        bit [63:0] unused;
        apb_access(1'b1, r, v, unused);
        sb.set_register(r, v);
        check_register(r);
    endtask

    task automatic apply_setting(bit [63:0] vmin, bit [63:0] scale, bit [63:0] entries);
        write_reg(tfc_pkg::REG_VALUE_MIN, vmin);
        write_reg(tfc_pkg::REG_RANGE_SCALE, scale);
        write_reg(tfc_pkg::REG_TABLE_ENTRIES, entries);
        settings++;
    endtask

    // register setting of one random phase
    task automatic pick_setting(int phase);
        bit [63:0] width;
        case (phase % 4)
            0: begin
                width = $urandom_range(1 << 20, 1);
                apply_setting(64'(32'($urandom_range(200000)) - 32'd100000),
                              (64'd1 << 32) / width, $urandom_range(256, 2));
            end
            1: apply_setting(64'h8000_0000, 64'd1, tfc_pkg::TABLE_DEPTH);
            2: apply_setting(64'(32'($urandom_range(2000)) - 32'd1000),
                             64'(tfc_pkg::SCALE_ONE), $urandom_range(511));
            default: apply_setting({32'd0, $urandom}, {31'd0, 1'($urandom), $urandom},
                                   $urandom_range(511));
        endcase
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // registers come up with their reset values
        check_register(tfc_pkg::REG_VALUE_MIN);
        check_register(tfc_pkg::REG_RANGE_SCALE);
        check_register(tfc_pkg::REG_TABLE_ENTRIES);

        // fill every table entry, extremes at both ends
        for (int i = 0; i < tfc_pkg::TABLE_DEPTH; i++) begin
            if (i == 0)
                queue_txn(write_txn(tfc_pkg::INDEX_W'(i), '1));
            else if (i == tfc_pkg::TABLE_DEPTH - 1)
                queue_txn(write_txn(tfc_pkg::INDEX_W'(i), '0));
            else
                queue_txn(write_txn(tfc_pkg::INDEX_W'(i),
                                    tfc_pkg::entry_t'({$urandom, $urandom})));
        end
        send_all();

        // reset setting: at and below the lower end, full scale, saturation
        queue_txn(classify_txn(32'sd0));
        queue_txn(classify_txn(-32'sd1));
        queue_txn(classify_txn(32'sh8000_0000));
        queue_txn(classify_txn(32'sh7fff_ffff));
        queue_txn(classify_txn(32'sd1));
        queue_txn(classify_txn(32'sd32768));
        queue_txn(classify_txn(32'sd65535));
        queue_txn(classify_txn(32'sd65536));
        // extreme entries next to each other, blended with a large fraction
        queue_txn(write_txn(8'd254, '1));
        queue_txn(write_txn(8'd255, '0));
        queue_txn(classify_txn(32'sd65535));
        queue_txn(classify_txn(32'sd65280));
        send_all();
        settle();

        // zero entries and a scale above one
        apply_setting(64'h7fff_ffff, 64'h1_ffff_ffff, 64'd0);
        queue_txn(classify_txn(32'sh7fff_ffff));
        queue_txn(classify_txn(32'sh8000_0000));
        queue_txn(classify_txn(32'sd0));
        send_all();
        settle();

        // widest difference, scale of exactly one, too many entries
        apply_setting(64'h8000_0000, 64'(tfc_pkg::SCALE_ONE), 64'd511);
        queue_txn(classify_txn(32'sh8000_0000));
        queue_txn(classify_txn(32'sh8000_0001));
        queue_txn(classify_txn(32'sh7fff_ffff));
        send_all();
        settle();

        // smallest scale with one entry, then two
        apply_setting(64'h8000_0000, 64'd1, 64'd1);
        queue_txn(classify_txn(32'sh7fff_ffff));
        queue_txn(classify_txn(32'sd0));
        send_all();
        settle();
        write_reg(tfc_pkg::REG_TABLE_ENTRIES, 64'd2);
        queue_txn(classify_txn(32'sh7fff_ffff));
        queue_txn(classify_txn(32'sd0));
        send_all();
        settle();
        apply_setting(64'd0, 64'd0, 64'd256);
        queue_txn(classify_txn(32'sh7fff_ffff));
        send_all();
        settle();

        // random phases, one of them without any idle cycles
        for (int p = 0; p < NUM_PHASES; p++) begin
            pick_setting(p);
            steady = (p == 5);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if ($urandom_range(99) < 18)
                    queue_txn(write_txn(tfc_pkg::INDEX_W'($urandom),
                                        tfc_pkg::entry_t'({$urandom, $urandom})));
                else
                    queue_txn(classify_txn(pick_sample()));
            end
            send_all();
            settle();
            steady = 1'b0;
        end

        $display("run covered %0d table writes and %0d classifications", sb.n_written,
                 sb.n_classified);
        $display("over %0d register settings, clamping and saturation included", settings);
        if (sb.mismatches == 0 && reg_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
